@@ rtl/core/met_pkg.sv @@
// ----------------------------------------------------------------------------
// met_pkg
// Shared types, constants and helpers of the escape-time core.
// ----------------------------------------------------------------------------
package met_pkg;

  // fixed-point format and field widths
  localparam int unsigned QW        = 32;
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned ROW_W     = 9;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // |z|^2 threshold of 4.0 in Q8.56
  localparam logic [63:0] ESCAPE_SQ = 64'd4 << (2 * FRAC_BITS);

  // register reset values
  localparam logic signed [QW-1:0] X_MIN_RST = 32'shE000_0000;
  localparam logic signed [QW-1:0] Y_MIN_RST = 32'shF000_0000;
  localparam logic [STEP_W-1:0]    X_STEP_RST = 31'd1260649;
  localparam logic [STEP_W-1:0]    Y_STEP_RST = 31'd1120875;
  localparam logic [CNT_W-1:0]     LIMIT_RST  = 8'd255;

  typedef logic signed [QW-1:0] q_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN  = 3'd0,
    REG_Y_MIN  = 3'd1,
    REG_X_STEP = 3'd2,
    REG_Y_STEP = 3'd3,
    REG_LIMIT  = 3'd4
  } reg_idx_e;

  // complex point handed from front to back
  typedef struct packed {
    q_t c_re;
    q_t c_im;
  } point_t;

  // clamp a wide signed value to the Q4.28 range
  function automatic q_t sat_q(input logic signed [63:0] v);
    q_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/met_if.sv @@
// ----------------------------------------------------------------------------
// met_if
// Valid/ready channels of the escape-time core: pixel in, count out, config.
// ----------------------------------------------------------------------------
interface met_pix_if;
  logic       valid;
  logic       ready;
  logic [9:0] column;
  logic [8:0] row;
  modport source (output valid, output column, output row, input ready);
  modport sink (input valid, input column, input row, output ready);
endinterface

interface met_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] escape_count;
  modport source (output valid, output escape_count, input ready);
  modport sink (input valid, input escape_count, output ready);
endinterface

interface met_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/met_front.sv @@
// ----------------------------------------------------------------------------
// met_front
// Clamps the pixel position and maps it to the complex point c.
// ----------------------------------------------------------------------------
module met_front import met_pkg::*; #(
  parameter int unsigned IMAGE_WIDTH  = 640,
  parameter int unsigned IMAGE_HEIGHT = 480
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  met_pix_if.sink           pix_i,
  input  q_t                x_min_i,
  input  q_t                y_min_i,
  input  logic [STEP_W-1:0] x_step_i,
  input  logic [STEP_W-1:0] y_step_i,
  output logic              push_valid_o,
  output point_t            push_data_o,
  input  logic              push_ready_i
);

  localparam int unsigned PW_X = COL_W + STEP_W;
  localparam int unsigned PW_Y = ROW_W + STEP_W;

  logic [12:0]       col_x, row_x;
  logic [COL_W-1:0]  col_c;
  logic [ROW_W-1:0]  row_c;
  logic              valid_q;
  logic [PW_X-1:0]   px_q;
  logic [PW_Y-1:0]   py_q;

  // positions past the image stick to the last column or row
  always_comb begin
    col_x = {3'b0, pix_i.column};
    row_x = {4'b0, pix_i.row};
    if (col_x >= 13'(IMAGE_WIDTH)) begin
      col_x = 13'(IMAGE_WIDTH - 1);
    end
    if (row_x >= 13'(IMAGE_HEIGHT)) begin
      row_x = 13'(IMAGE_HEIGHT - 1);
    end
    col_c = col_x[COL_W-1:0];
    row_c = row_x[ROW_W-1:0];
  end

  assign pix_i.ready = !valid_q || push_ready_i;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      px_q <= PW_X'(col_c) * PW_X'(x_step_i);
      py_q <= PW_Y'(row_c) * PW_Y'(y_step_i);
    end
  end

  // edge plus offset, saturated
  assign push_valid_o      = valid_q;
  assign push_data_o.c_re  = sat_q($signed(64'(px_q)) + 64'(x_min_i));
  assign push_data_o.c_im  = sat_q($signed(64'(py_q)) + 64'(y_min_i));

endmodule

@@ rtl/core/met_fifo.sv @@
// ----------------------------------------------------------------------------
// met_fifo
// Short queue of complex points between the front and the iteration unit.
// ----------------------------------------------------------------------------
module met_fifo import met_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  input  point_t push_data_i,
  output logic   push_ready_o,
  output logic   pop_valid_o,
  output point_t pop_data_o,
  input  logic   pop_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  point_t         mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;
  logic           push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/met_back.sv @@
// ----------------------------------------------------------------------------
// met_back
// Iteration unit: z = z*z + c with escape test, and the result register.
// ----------------------------------------------------------------------------
module met_back import met_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  input  point_t           pop_data_i,
  output logic             pop_o,
  input  logic [CNT_W-1:0] limit_i,
  met_res_if.source        res_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_UPD, S_OUT} state_e;

  state_e             state_q;
  point_t             c_q;
  q_t                 re_q, im_q, re_d, im_d;
  logic [CNT_W-1:0]   cnt_q, res_cnt_q, out_cnt_q;
  logic               out_valid_q;
  logic signed [63:0] rr_q, ii_q, ri_q;
  logic signed [63:0] rr_d, ii_d, ri_d, diff;
  logic [63:0]        mag;
  logic               escaped, out_free;

  assign pop_o    = (state_q == S_IDLE) && pop_valid_i;
  assign out_free = !out_valid_q || res_o.ready;

  // squares and cross product of z
  always_comb begin
    rr_d = re_q * re_q;
    ii_d = im_q * im_q;
    ri_d = re_q * im_q;
  end

  // escape test and next z, floor rounding then saturation
  always_comb begin
    mag     = $unsigned(rr_q) + $unsigned(ii_q);
    escaped = (mag >= ESCAPE_SQ);
    diff    = rr_q - ii_q;
    re_d    = sat_q((diff >>> FRAC_BITS) + 64'(c_q.c_re));
    im_d    = sat_q((ri_q >>> (FRAC_BITS - 1)) + 64'(c_q.c_im));
  end

  // sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      c_q         <= '0;
      re_q        <= '0;
      im_q        <= '0;
      cnt_q       <= '0;
      res_cnt_q   <= '0;
      out_cnt_q   <= '0;
      rr_q        <= '0;
      ii_q        <= '0;
      ri_q        <= '0;
    end else begin
      // result register fills from the sequencer, empties on hand-off
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.valid && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_valid_i) begin
            c_q     <= pop_data_i;
            re_q    <= '0;
            im_q    <= '0;
            cnt_q   <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt_q >= limit_i) begin
            res_cnt_q <= '0;
            state_q   <= S_OUT;
          end else begin
            rr_q    <= rr_d;
            ii_q    <= ii_d;
            ri_q    <= ri_d;
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (escaped) begin
            res_cnt_q <= cnt_q;
            state_q   <= S_OUT;
          end else begin
            re_q    <= re_d;
            im_q    <= im_d;
            cnt_q   <= cnt_q + CNT_W'(1);
            state_q <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_cnt_q <= res_cnt_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.escape_count = out_cnt_q;

endmodule

@@ rtl/core/mandelbrot_escape_time_core.sv @@
// A pixel (column, row) enters, is mapped to c = (x_min + column*x_step,
// y_min + row*y_step) in signed Q4.28 and iterated as z = z*z + c from zero;
// one escape_count word leaves per pixel, 0 when iteration_limit was reached.
// The iteration unit forms registered 32x32 products and then adds,
// saturates and does the escape compare. The front stage maps the next
// pixels while a pixel iterates, and a finished count waits in the output
// register while the unit already starts on the next pixel. Configuration
// is taken every cycle and should only change while no pixel is in flight.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// Escape-time count of one Mandelbrot pixel per input word.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core import met_pkg::*; #(
  parameter int unsigned IMAGE_WIDTH  = 640,
  parameter int unsigned IMAGE_HEIGHT = 480,
  parameter int unsigned QUEUE_DEPTH  = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  met_cfg_if.sink   cfg_i,
  met_pix_if.sink   pix_i,
  met_res_if.source res_o
);

  q_t                x_min_q, y_min_q;
  logic [STEP_W-1:0] x_step_q, y_step_q;
  logic [CNT_W-1:0]  limit_q;
  logic              push_valid, push_ready, pop_valid, pop;
  point_t            push_data, pop_data;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q  <= X_MIN_RST;
      y_min_q  <= Y_MIN_RST;
      x_step_q <= X_STEP_RST;
      y_step_q <= Y_STEP_RST;
      limit_q  <= LIMIT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_X_MIN:  x_min_q  <= cfg_i.data;
        REG_Y_MIN:  y_min_q  <= cfg_i.data;
        REG_X_STEP: x_step_q <= cfg_i.data[STEP_W-1:0];
        REG_Y_STEP: y_step_q <= cfg_i.data[STEP_W-1:0];
        REG_LIMIT:  limit_q  <= cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel to point mapping
  met_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .x_min_i      (x_min_q),
    .y_min_i      (y_min_q),
    .x_step_i     (x_step_q),
    .y_step_i     (y_step_q),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // point queue
  met_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_i        (pop)
  );

  // iteration unit
  met_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .limit_i     (limit_q),
    .res_o       (res_o)
  );

endmodule

@@ rtl/core/met_checker.sv @@
// ----------------------------------------------------------------------------
// met_checker
// Port-level checks of the escape-time core, bound to the top level.
// ----------------------------------------------------------------------------
module met_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pix_valid_i,
  input logic       pix_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] res_count_i
);

  logic [7:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = pix_valid_i && pix_ready_i;
  assign out_acc = res_valid_i && res_ready_i;

  // words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 8'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 8'd1;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_count_i))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_count_i != 8'hFF)
    else $error("escape count out of range");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> pending_q != 8'd0)
    else $error("result without a pending pixel");

endmodule

bind mandelbrot_escape_time_core met_checker u_met_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_count_i (res_o.escape_count)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel words into the escape-time core under a series of views and
// compares every returned escape count with a local fixed-point prediction.
// ----------------------------------------------------------------------------
module testbench;
  import met_pkg::*;

  localparam int unsigned IMAGE_WIDTH   = 640;
  localparam int unsigned IMAGE_HEIGHT  = 480;
  localparam int unsigned RANDOM_PIXELS = 1210;
  localparam int unsigned DRAIN_CYCLES  = 600;
  localparam int unsigned STALL_CYCLES  = 400;

  // 4.0 in Q8.56 and the Q4.28 range
  localparam logic [63:0]        RADIUS_SQ_Q56 = 64'd4 << 56;
  localparam logic signed [63:0] Q_HIGH        = 64'sd2147483647;
  localparam logic signed [63:0] Q_LOW         = -64'sd2147483648;

  localparam logic [CFG_DAT_W-1:0] Q_MOST_POS = 32'h7FFF_FFFF;
  localparam logic [CFG_DAT_W-1:0] Q_MOST_NEG = 32'h8000_0000;
  localparam logic [CFG_DAT_W-1:0] STEP_ALL   = 32'hFFFF_FFFF;
  localparam logic [CFG_DAT_W-1:0] STEP_NONE  = 32'h0000_0000;

  // view after reset
  localparam logic [CFG_DAT_W-1:0] HOME_X_MIN  = -32'sd536870912;
  localparam logic [CFG_DAT_W-1:0] HOME_Y_MIN  = -32'sd268435456;
  localparam logic [CFG_DAT_W-1:0] HOME_X_STEP = 32'd1260649;
  localparam logic [CFG_DAT_W-1:0] HOME_Y_STEP = 32'd1120875;
  localparam logic [CNT_W-1:0]     HOME_LIMIT  = 8'd255;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic clk;
  logic rst_n;

  met_cfg_if cfg_if ();
  met_pix_if pix_if ();
  met_res_if res_if ();

  mandelbrot_escape_time_core #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .pix_i (pix_if),
    .res_o (res_if)
  );

  // local copy of the view registers
  q_t                view_x_min;
  q_t                view_y_min;
  logic [STEP_W-1:0] view_x_step;
  logic [STEP_W-1:0] view_y_step;
  logic [CNT_W-1:0]  view_limit;

  logic [CNT_W-1:0] counts_due[$];
  logic [CNT_W-1:0] due_count;

  logic        tx_gaps;
  logic        rx_gaps;
  logic        pixel_offered;
  int unsigned stall_request;
  int unsigned stall_left;
  int unsigned pixels_sent;
  int unsigned counts_checked;
  int unsigned views_loaded;
  int unsigned failures;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #(40_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // clamp to Q4.28
  function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
    if (v > Q_HIGH) return Q_HIGH;
    if (v < Q_LOW) return Q_LOW;
    return v;
  endfunction

  // escape count of one pixel under the current view
  function automatic logic [CNT_W-1:0] escape_count_of(input logic [COL_W-1:0] column,
                                                       input logic [ROW_W-1:0] row);
    logic [63:0]        col_w;
    logic [63:0]        row_w;
    logic signed [63:0] x0;
    logic signed [63:0] y0;
    logic signed [63:0] c_re;
    logic signed [63:0] c_im;
    logic signed [63:0] re;
    logic signed [63:0] im;
    logic signed [63:0] rr;
    logic signed [63:0] ii;
    logic signed [63:0] ri;
    logic [63:0]        mag_sq;
    int unsigned        steps;
    // pixels past the image stick to the last column or row
    col_w = (column >= IMAGE_WIDTH) ? 64'(IMAGE_WIDTH - 1) : 64'(column);
    row_w = (row >= IMAGE_HEIGHT) ? 64'(IMAGE_HEIGHT - 1) : 64'(row);
    x0    = view_x_min;
    y0    = view_y_min;
    c_re  = clamp_q(x0 + $signed(col_w * 64'(view_x_step)));
    c_im  = clamp_q(y0 + $signed(row_w * 64'(view_y_step)));
    re    = '0;
    im    = '0;
    steps = 0;
    while (steps < view_limit) begin
      rr     = re * re;
      ii     = im * im;
      ri     = re * im;
      mag_sq = rr + ii;
      if (mag_sq >= RADIUS_SQ_Q56) break;
      // products rounded toward minus infinity, then saturated
      re = clamp_q(((rr - ii) >>> FRAC_BITS) + c_re);
      im = clamp_q((ri >>> (FRAC_BITS - 1)) + c_im);
      steps++;
    end
    return (steps < view_limit) ? CNT_W'(steps) : '0;
  endfunction

  // one register write, local view follows on acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DAT_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (index)
      REG_X_MIN:  view_x_min  = data;
      REG_Y_MIN:  view_y_min  = data;
      REG_X_STEP: view_x_step = data[STEP_W-1:0];
      REG_Y_STEP: view_y_step = data[STEP_W-1:0];
      REG_LIMIT:  view_limit  = data[CNT_W-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // withdraw the pixel word and let every count come back
  task automatic wait_idle();
    if (pixel_offered) begin
      pix_if.valid <= 1'b0;
      pixel_offered = 1'b0;
    end
    while (counts_due.size() != 0) @(posedge clk);
  endtask

  task automatic load_view(input logic [CFG_DAT_W-1:0] x_min, input logic [CFG_DAT_W-1:0] y_min,
                           input logic [CFG_DAT_W-1:0] x_step,
                           input logic [CFG_DAT_W-1:0] y_step, input logic [CNT_W-1:0] limit);
    wait_idle();
    write_reg(REG_X_MIN, x_min);
    write_reg(REG_Y_MIN, y_min);
    write_reg(REG_X_STEP, x_step);
    write_reg(REG_Y_STEP, y_step);
    write_reg(REG_LIMIT, CFG_DAT_W'(limit));
    views_loaded++;
  endtask

  task automatic set_limit(input logic [CNT_W-1:0] limit);
    wait_idle();
    write_reg(REG_LIMIT, CFG_DAT_W'(limit));
  endtask

  // offer one pixel word, record its count once taken
  task automatic send_pixel(input logic [COL_W-1:0] column, input logic [ROW_W-1:0] row);
    while (tx_gaps && $urandom_range(99) < 32) begin
      if (pixel_offered) begin
        pix_if.valid <= 1'b0;
        pixel_offered = 1'b0;
      end
      @(posedge clk);
    end
    pix_if.valid  <= 1'b1;
    pix_if.column <= column;
    pix_if.row    <= row;
    pixel_offered = 1'b1;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    counts_due.push_back(escape_count_of(column, row));
    pixels_sent++;
  endtask

  // output side: random stalls plus one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (stall_request != 0) begin
        stall_left = stall_request - 1;
        stall_request = 0;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !(rx_gaps && $urandom_range(99) < 32);
      end
    end
  end

  // compare each count word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (counts_due.size() == 0) begin
        failures++;
        $display("%0t: escape count %0d with nothing expected", $time, res_if.escape_count);
      end else begin
        due_count = counts_due.pop_front();
        counts_checked++;
        if (res_if.escape_count !== due_count) begin
          failures++;
          $display("%0t: escape count mismatch, expected %0d, actual %0d", $time, due_count,
                   res_if.escape_count);
        end
      end
    end
  end

  // corners, interior points and pixels past the image at the reset view
  task automatic test_reset_view();
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd639, 9'd479);
    send_pixel(10'd1023, 9'd511);
    send_pixel(10'd640, 9'd480);
    send_pixel(10'd400, 9'd240);
    send_pixel(10'd0, 9'd479);
    send_pixel(10'd639, 9'd0);
    send_pixel(10'd512, 9'd256);
  endtask

  // no iteration at all
  task automatic test_zero_limit();
    set_limit(8'd0);
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd1023, 9'd511);
    send_pixel(10'd400, 9'd240);
  endtask

  // limit of one never escapes, limit of two lets far points escape
  task automatic test_small_limits();
    set_limit(8'd1);
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd400, 9'd240);
    set_limit(8'd2);
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd400, 9'd240);
  endtask

  // points pinned at the edges of the number range
  task automatic test_saturated_points();
    load_view(Q_MOST_POS, Q_MOST_NEG, STEP_ALL, STEP_ALL, HOME_LIMIT);
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd639, 9'd479);
    send_pixel(10'd1023, 9'd0);
    load_view(Q_MOST_NEG, Q_MOST_POS, STEP_NONE, STEP_NONE, HOME_LIMIT);
    send_pixel(10'd5, 9'd5);
  endtask

  // a write to an unused index leaves the view alone
  task automatic test_spare_index();
    load_view(HOME_X_MIN, HOME_Y_MIN, HOME_X_STEP, HOME_Y_STEP, 8'd40);
    write_reg(REG_SPARE, $urandom());
    send_pixel(10'd320, 9'd240);
    send_pixel(10'd100, 9'd300);
  endtask

  // long output stall while pixels keep coming
  task automatic test_backpressure();
    load_view(HOME_X_MIN, HOME_Y_MIN, HOME_X_STEP, HOME_Y_STEP, 8'd20);
    tx_gaps = 1'b0;
    stall_request = STALL_CYCLES;
    repeat (16) send_pixel(COL_W'($urandom_range(IMAGE_WIDTH - 1)),
                           ROW_W'($urandom_range(IMAGE_HEIGHT - 1)));
    tx_gaps = 1'b1;
  endtask

  // pick a view: mostly framed near the set, sometimes extreme or arbitrary
  task automatic random_view();
    logic [CFG_DAT_W-1:0] x_min;
    logic [CFG_DAT_W-1:0] y_min;
    logic [CFG_DAT_W-1:0] x_step;
    logic [CFG_DAT_W-1:0] y_step;
    logic [CNT_W-1:0]     limit;
    int unsigned          zoom;
    case ($urandom_range(7))
      0: begin
        x_min  = $urandom_range(1) ? Q_MOST_POS : Q_MOST_NEG;
        y_min  = $urandom_range(1) ? Q_MOST_POS : Q_MOST_NEG;
        x_step = $urandom_range(1) ? STEP_ALL : STEP_NONE;
        y_step = $urandom_range(1) ? STEP_ALL : STEP_NONE;
      end
      1: begin
        x_min  = $urandom();
        y_min  = $urandom();
        x_step = $urandom();
        y_step = $urandom();
      end
      default: begin
        zoom   = $urandom_range(6, 21);
        x_min  = 32'(-671088640 + $urandom_range(939524096));
        y_min  = 32'(-402653184 + $urandom_range(805306368));
        x_step = $urandom_range(1, 1 << zoom);
        y_step = $urandom_range(1, 1 << zoom);
        // top bit lies beyond the step register
        x_step[CFG_DAT_W-1] = 1'($urandom_range(1));
        y_step[CFG_DAT_W-1] = 1'($urandom_range(1));
      end
    endcase
    case ($urandom_range(9))
      0: limit = HOME_LIMIT;
      1: limit = CNT_W'($urandom_range(255));
      default: limit = CNT_W'($urandom_range(2, 48));
    endcase
    load_view(x_min, y_min, x_step, y_step, limit);
  endtask

  // batches of random pixels, one random view per batch
  task automatic test_random_views();
    int unsigned target;
    int unsigned batch;
    int unsigned phase;
    target = pixels_sent + RANDOM_PIXELS;
    phase  = 0;
    while (pixels_sent < target) begin
      random_view();
      batch = $urandom_range(60, 140);
      // last batch stops at the pixel budget
      if (batch > target - pixels_sent) begin
        batch = target - pixels_sent;
      end
      // one stretch with no idling on either side
      tx_gaps = (phase != 2);
      rx_gaps = (phase != 2);
      repeat (batch) begin
        if ($urandom_range(9) == 0) begin
          send_pixel(COL_W'($urandom()), ROW_W'($urandom()));
        end else begin
          send_pixel(COL_W'($urandom_range(IMAGE_WIDTH - 1)),
                     ROW_W'($urandom_range(IMAGE_HEIGHT - 1)));
        end
      end
      phase++;
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // reset, tests in turn, drain and verdict
  initial begin
    rst_n         <= 1'b0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= REG_X_MIN;
    cfg_if.data   <= '0;
    pix_if.valid  <= 1'b0;
    pix_if.column <= '0;
    pix_if.row    <= '0;
    view_x_min     = HOME_X_MIN;
    view_y_min     = HOME_Y_MIN;
    view_x_step    = HOME_X_STEP[STEP_W-1:0];
    view_y_step    = HOME_Y_STEP[STEP_W-1:0];
    view_limit     = HOME_LIMIT;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    pixel_offered  = 1'b0;
    stall_request  = 0;
    stall_left     = 0;
    pixels_sent    = 0;
    counts_checked = 0;
    views_loaded   = 0;
    failures       = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_view();
    test_zero_limit();
    test_small_limits();
    test_saturated_points();
    test_spare_index();
    test_backpressure();
    test_random_views();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    failures += counts_due.size();

    $display("%0d pixels sent over %0d loaded views, %0d escape counts compared",
             pixels_sent, views_loaded, counts_checked);
    $display("views ranged over zero and small limits, pinned edges, off-image pixels, stalls");
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/met_pkg.sv
rtl/core/met_if.sv
rtl/core/met_front.sv
rtl/core/met_fifo.sv
rtl/core/met_back.sv
rtl/core/mandelbrot_escape_time_core.sv
rtl/core/met_checker.sv
tb/testbench.sv
